// File: rtl/radial_falloff_alpha_pixel_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the soft disc shader
// Shared helpers that write clocked implication checks in one line.
// ----------------------------------------------------------------------------
`ifndef RADIAL_FALLOFF_ALPHA_PIXEL_TOP_ASSERT_SVH
`define RADIAL_FALLOFF_ALPHA_PIXEL_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RFA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rfa: implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define RFA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rfa: next-cycle check failed");

`endif

// File: rtl/rfa_pkg.sv
// ----------------------------------------------------------------------------
// rfa_pkg
// Types, register indexes and constant functions of the soft disc shader.
// ----------------------------------------------------------------------------
package rfa_pkg;

  localparam int QueueDepth = 4;
  localparam int CfgIdxW    = 3;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_FILL_COLOR     = 3'd0,
    CFG_RADIUS         = 3'd1,
    CFG_SHAPE_EXPONENT = 3'd2,
    CFG_CENTER_X       = 3'd3,
    CFG_CENTER_Y       = 3'd4
  } cfg_idx_e;

  // Absolute offsets of one pixel from the disc center.
  typedef struct packed {
    logic [16:0] ax;
    logic [16:0] ay;
  } ofs_t;

  // Head of the queue between the front and the back.
  typedef struct packed {
    logic valid;
    ofs_t ofs;
  } front_q_t;

  // Flags that travel with a pixel through the back pipeline.
  typedef struct packed {
    logic v;
    logic kz;
    logic kc;
  } flags_t;

  // Floored integer square root, bit by bit.
  function automatic logic [63:0] isqrt64(input logic [63:0] n_in);
    logic [63:0] n;
    logic [63:0] res;
    logic [63:0] bm;
    n   = n_in;
    res = '0;
    bm  = 64'h4000_0000_0000_0000;
    for (int i = 0; i < 32; i++) begin
      if (n >= res + bm) begin
        n   = n - (res + bm);
        res = (res >> 1) + bm;
      end else begin
        res = res >> 1;
      end
      bm = bm >> 2;
    end
    return res;
  endfunction

  // 2^(-2^-k) in Q0.32, built from repeated square roots.
  function automatic logic [31:0] exp_const(input int k);
    logic [63:0] c;
    c = isqrt64(64'h8000_0000_0000_0000);
    for (int j = 1; j < k; j++) begin
      c = isqrt64(c << 32);
    end
    return c[31:0];
  endfunction

endpackage

// File: rtl/radial_falloff_alpha_pixel_top.sv
// ----------------------------------------------------------------------------
// radial_falloff_alpha_pixel_top
// Soft disc shader: fill color and radial coverage for one pixel per request.
// ----------------------------------------------------------------------------
// The block takes one pixel request per clock and returns one result per
// clock at a sustained rate while the output is not stalled, in request
// order. The 36-stage divider that forms the 1/rho root is the longest
// part of the path from request to result. Pixel requests are taken
// while the short queue behind the front has room, even while a finished
// result waits on the output. Configuration writes are always taken and
// should be made only while no pixel is in flight.
module radial_falloff_alpha_pixel_top #(
  parameter int QueueDepth = rfa_pkg::QueueDepth
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [rfa_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [23:0]                 cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic signed [15:0]          x_pos_i,
  input  logic signed [15:0]          y_pos_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [7:0]                  red_o,
  output logic [7:0]                  green_o,
  output logic [7:0]                  blue_o,
  output logic [15:0]                 alpha_o
);

  `include "radial_falloff_alpha_pixel_top_assert.svh"

  logic [23:0]       fill_color_q;
  logic [15:0]       radius_q;
  logic [14:0]       rho_q;
  logic [15:0]       center_x_q, center_y_q;
  logic [14:0]       rho_code;
  rfa_pkg::front_q_t fq;
  logic              pop;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_color_q <= '0;
      radius_q     <= 16'd32768;
      rho_q        <= 15'd15565;
      center_x_q   <= '0;
      center_y_q   <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (rfa_pkg::cfg_idx_e'(cfg_index_i))
        rfa_pkg::CFG_FILL_COLOR:     fill_color_q <= cfg_data_i;
        rfa_pkg::CFG_RADIUS:         radius_q     <= cfg_data_i[15:0];
        rfa_pkg::CFG_SHAPE_EXPONENT: rho_q        <= cfg_data_i[14:0];
        rfa_pkg::CFG_CENTER_X:       center_x_q   <= cfg_data_i[15:0];
        rfa_pkg::CFG_CENTER_Y:       center_y_q   <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // An exponent code of zero behaves as the smallest nonzero code.
  assign rho_code = (rho_q == '0) ? 15'd1 : rho_q;

  rfa_front #(.Depth(QueueDepth)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .x_pos_i    (x_pos_i),
    .y_pos_i    (y_pos_i),
    .center_x_i (center_x_q),
    .center_y_i (center_y_q),
    .pop_i      (pop),
    .fq_o       (fq)
  );

  rfa_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fq_i        (fq),
    .pop_o       (pop),
    .out_stall_i (out_stall_i),
    .radius_i    (radius_q),
    .rho_i       (rho_code),
    .out_valid_o (out_valid_o),
    .alpha_o     (alpha_o)
  );

  assign red_o   = fill_color_q[23:16];
  assign green_o = fill_color_q[15:8];
  assign blue_o  = fill_color_q[7:0];

  `RFA_ASSERT_IMP(a_zero_radius_clear, clk_i, rst_ni, out_valid_o && (radius_q == '0), alpha_o == '0)
  `RFA_ASSERT_IMP(a_queue_drains, clk_i, rst_ni, fq.valid && !(out_valid_o && out_stall_i), pop)
  `RFA_ASSERT_IMP(a_full_not_empty, clk_i, rst_ni, in_stall_o, fq.valid)

endmodule

// File: rtl/rfa_front.sv
// ----------------------------------------------------------------------------
// rfa_front
// Takes pixel requests, forms the offsets from the center and queues them.
// ----------------------------------------------------------------------------
module rfa_front #(
  parameter int Depth = rfa_pkg::QueueDepth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [15:0] x_pos_i,
  input  logic signed [15:0] y_pos_i,
  input  logic        [15:0] center_x_i,
  input  logic        [15:0] center_y_i,
  input  logic               pop_i,
  output rfa_pkg::front_q_t  fq_o
);

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

  rfa_pkg::ofs_t  mem_q [Depth];
  logic [AW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [AW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [AW:0]    cnt_q, cnt_d;
  logic           push, pop;
  logic [16:0]    dx, dy;
  rfa_pkg::ofs_t  ofs;

  assign in_stall_o = (cnt_q == (AW+1)'(Depth));
  assign push       = in_valid_i && !in_stall_o;
  assign pop        = pop_i && (cnt_q != '0);

  always_comb begin
    dx = {center_x_i[15], center_x_i} - {x_pos_i[15], x_pos_i};
    dy = {center_y_i[15], center_y_i} - {y_pos_i[15], y_pos_i};
    ofs.ax = dx[16] ? (17'd0 - dx) : dx;
    ofs.ay = dy[16] ? (17'd0 - dy) : dy;
  end

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == AW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == AW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= ofs;
    end
  end

  assign fq_o.valid = (cnt_q != '0);
  assign fq_o.ofs   = mem_q[rd_ptr_q];

endmodule

// File: rtl/rfa_log.sv
// ----------------------------------------------------------------------------
// rfa_log
// Pipelined log2 in Q.16: leading-one search, then one squaring per stage.
// ----------------------------------------------------------------------------
module rfa_log #(
  parameter int W  = 32,
  parameter int TW = 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic [W-1:0]       x_i,
  input  logic [TW-1:0]      tag_i,
  output logic [$clog2(W)+15:0] q_o,
  output logic [TW-1:0]      tag_o
);

  localparam int EW = $clog2(W);

  logic [EW-1:0] lead;
  logic [EW-1:0] sh;
  logic [W-1:0]  nrm;

  logic [31:0]   m_q [17];
  logic [15:0]   f_q [17];
  logic [EW-1:0] e_q [17];
  logic [TW-1:0] t_q [17];

  always_comb begin
    lead = '0;
    for (int i = 0; i < W; i++) begin
      if (x_i[i]) begin
        lead = EW'(i);
      end
    end
    sh  = EW'(W - 1) - lead;
    nrm = x_i << sh;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m_q[0] <= nrm[W-1 -: 32];
      f_q[0] <= '0;
      e_q[0] <= lead;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t_q[0] <= '0;
    end else if (en_i) begin
      t_q[0] <= tag_i;
    end
  end

  for (genvar g = 1; g <= 16; g++) begin : g_sq
    logic [63:0] sq;
    logic [32:0] s33;

    assign sq  = m_q[g-1] * m_q[g-1];
    assign s33 = sq[63:31];

    // A square at or above two yields a one in this fraction bit.
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        e_q[g] <= e_q[g-1];
        if (s33[32]) begin
          m_q[g] <= s33[32:1];
          f_q[g] <= f_q[g-1] | (16'd1 << (16 - g));
        end else begin
          m_q[g] <= s33[31:0];
          f_q[g] <= f_q[g-1];
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        t_q[g] <= '0;
      end else if (en_i) begin
        t_q[g] <= t_q[g-1];
      end
    end
  end

  assign q_o   = {e_q[16], f_q[16]};
  assign tag_o = t_q[16];

endmodule

// File: rtl/rfa_exp.sv
// ----------------------------------------------------------------------------
// rfa_exp
// Pipelined 2^(-m/65536) in Q1.32: one constant product per fraction bit.
// ----------------------------------------------------------------------------
module rfa_exp #(
  parameter int MW = 21,
  parameter int TW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic [MW-1:0] m_i,
  input  logic [TW-1:0] tag_i,
  output logic [32:0]   y_o,
  output logic [TW-1:0] tag_o
);

  logic [32:0]   r_q  [17];
  logic [MW-1:0] mm_q [17];
  logic [TW-1:0] t_q  [17];
  logic [32:0]   y_q;
  logic [TW-1:0] ty_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q[0]  <= 33'h1_0000_0000;
      mm_q[0] <= m_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t_q[0] <= '0;
      ty_q   <= '0;
    end else if (en_i) begin
      t_q[0] <= tag_i;
      ty_q   <= t_q[16];
    end
  end

  for (genvar g = 1; g <= 16; g++) begin : g_mul
    localparam logic [31:0] C = rfa_pkg::exp_const(g);
    logic [64:0] prod;

    assign prod = r_q[g-1] * C;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        mm_q[g] <= mm_q[g-1];
        r_q[g]  <= mm_q[g-1][16-g] ? prod[64:32] : r_q[g-1];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        t_q[g] <= '0;
      end else if (en_i) begin
        t_q[g] <= t_q[g-1];
      end
    end
  end

  // Shifts of 33 or more clear the value, which covers every large integer part.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      y_q <= r_q[16] >> mm_q[16][MW-1:16];
    end
  end

  assign y_o   = y_q;
  assign tag_o = ty_q;

endmodule

// File: rtl/rfa_div.sv
// ----------------------------------------------------------------------------
// rfa_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module rfa_div #(
  parameter int NW = 36,
  parameter int DW = 15,
  parameter int TW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic [NW-1:0] n_i,
  input  logic [DW-1:0] d_i,
  input  logic [TW-1:0] tag_i,
  output logic [NW-1:0] q_o,
  output logic [TW-1:0] tag_o
);

  logic [DW-1:0] rem_q [NW+1];
  logic [NW-1:0] n_q   [NW+1];
  logic [NW-1:0] q_q   [NW+1];
  logic [TW-1:0] t_q   [NW+1];

  assign rem_q[0] = '0;
  assign n_q[0]   = n_i;
  assign q_q[0]   = '0;
  assign t_q[0]   = tag_i;

  for (genvar g = 1; g <= NW; g++) begin : g_bit
    logic [DW:0] trial;
    logic [DW:0] diff;
    logic        ge;

    assign trial = {rem_q[g-1], n_q[g-1][NW-1]};
    assign ge    = (trial >= {1'b0, d_i});
    assign diff  = trial - {1'b0, d_i};

    // The remainder stays below the divisor, so it fits DW bits.
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[g] <= ge ? diff[DW-1:0] : trial[DW-1:0];
        n_q[g]   <= n_q[g-1] << 1;
        q_q[g]   <= {q_q[g-1][NW-2:0], ge};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        t_q[g] <= '0;
      end else if (en_i) begin
        t_q[g] <= t_q[g-1];
      end
    end
  end

  assign q_o   = q_q[NW];
  assign tag_o = t_q[NW];

endmodule

// File: rtl/rfa_back.sv
// ----------------------------------------------------------------------------
// rfa_back
// Coverage pipeline: distance, logs, power, root and output register.
// ----------------------------------------------------------------------------
module rfa_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rfa_pkg::front_q_t fq_i,
  output logic              pop_o,
  input  logic              out_stall_i,
  input  logic [15:0]       radius_i,
  input  logic [14:0]       rho_i,
  output logic              out_valid_o,
  output logic [15:0]       alpha_o
);

  logic adv;

  logic               v1_q;
  logic [33:0]        sqx_q, sqy_q;

  logic [33:0]        s_sum;
  logic [35:0]        s4;
  logic [31:0]        rr;
  rfa_pkg::flags_t    f2_d, f2_q;
  logic [31:0]        s4_q, r_q;

  logic [20:0]        lr, ls;
  logic               lr_tag;
  logic [1:0]         ls_tag;
  rfa_pkg::flags_t    f3;

  logic [20:0]        n1;
  logic [35:0]        tprod;
  logic [20:0]        t4_q;
  rfa_pkg::flags_t    f4_q;

  logic [32:0]        e5;
  rfa_pkg::flags_t    f5;

  logic [32:0]        v6_d, v6_q;
  rfa_pkg::flags_t    f6_q;

  logic [21:0]        lv;
  rfa_pkg::flags_t    f7;

  logic [21:0]        n2;
  logic [35:0]        dvd_q;
  rfa_pkg::flags_t    f8_q;

  logic [35:0]        quo;
  rfa_pkg::flags_t    f9;

  logic [32:0]        e10;
  rfa_pkg::flags_t    f10;

  logic [15:0]        alpha_d, alpha_q;
  logic               out_valid_q;

  // The whole pipeline moves together whenever the output can move.
  assign adv   = !out_valid_q || !out_stall_i;
  assign pop_o = adv && fq_i.valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      f2_q <= '0;
      f4_q <= '0;
      f6_q <= '0;
      f8_q <= '0;
    end else if (adv) begin
      v1_q <= fq_i.valid;
      f2_q <= f2_d;
      f4_q <= f3;
      f6_q <= '{v: f5.v, kz: f5.kz || (v6_d == '0), kc: f5.kc};
      f8_q <= f7;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sqx_q <= fq_i.ofs.ax * fq_i.ofs.ax;
      sqy_q <= fq_i.ofs.ay * fq_i.ofs.ay;
    end
  end

  // Pixels on or beyond the rim, and any pixel of a zero radius, are clear.
  always_comb begin
    s_sum   = sqx_q + sqy_q;
    s4      = {s_sum, 2'b00};
    rr      = radius_i * radius_i;
    f2_d.v  = v1_q;
    f2_d.kz = (radius_i == '0) || (s4 >= {4'b0000, rr});
    f2_d.kc = (s_sum == '0);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s4_q <= s4[31:0];
      r_q  <= rr;
    end
  end

  rfa_log #(.W(32), .TW(1)) u_log_r (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .x_i    (r_q),
    .tag_i  (f2_q.v),
    .q_o    (lr),
    .tag_o  (lr_tag)
  );

  rfa_log #(.W(32), .TW(2)) u_log_s (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .x_i    (s4_q),
    .tag_i  ({f2_q.kz, f2_q.kc}),
    .q_o    (ls),
    .tag_o  (ls_tag)
  );

  assign f3 = '{v: lr_tag, kz: ls_tag[1], kc: ls_tag[0]};

  always_comb begin
    n1    = (lr > ls) ? (lr - ls) : '0;
    tprod = n1 * rho_i;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      t4_q <= tprod[35:15];
    end
  end

  rfa_exp #(.MW(21), .TW(3)) u_exp_pow (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .m_i    (t4_q),
    .tag_i  (f4_q),
    .y_o    (e5),
    .tag_o  (f5)
  );

  assign v6_d = 33'h1_0000_0000 - e5;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      v6_q <= v6_d;
    end
  end

  rfa_log #(.W(33), .TW(3)) u_log_v (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .x_i    (v6_q),
    .tag_i  (f6_q),
    .q_o    (lv),
    .tag_o  (f7)
  );

  assign n2 = (lv < 22'h20_0000) ? (22'h20_0000 - lv) : '0;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dvd_q <= {n2, 14'd0};
    end
  end

  rfa_div #(.NW(36), .DW(15), .TW(3)) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .n_i    (dvd_q),
    .d_i    (rho_i),
    .tag_i  (f8_q),
    .q_o    (quo),
    .tag_o  (f9)
  );

  rfa_exp #(.MW(36), .TW(3)) u_exp_root (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .m_i    (quo),
    .tag_i  (f9),
    .y_o    (e10),
    .tag_o  (f10)
  );

  always_comb begin
    if (f10.kz) begin
      alpha_d = '0;
    end else if (f10.kc || e10[32]) begin
      alpha_d = 16'hFFFF;
    end else begin
      alpha_d = e10[31:16];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= f10.v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      alpha_q <= alpha_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign alpha_o     = alpha_q;

endmodule
